@@ design/cdq_pkg.sv @@
// Package for the positional circular deque: request and response item types,
// request codes, and the controller/datapath command and status groups.
// No dependencies.
package cdq_pkg;

    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic put;
        logic rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic is_read;
        logic is_insert;
        logic moves_done;
        logic out_busy;
    } t_sts;

endpackage

@@ design/circular_deque_positional_core.sv @@
// Top level of the positional circular deque: an ordered list in a circular
// slot memory with insert, remove and read at a 1-based position.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
//   channel   direction  handshake                 payload
//   request   in         i_req_valid / o_req_ready  i_req (req_type, position, value)
//   response  out        o_rsp_valid / i_rsp_ready  o_rsp (ok, read_value, count)
//
// One item at a time. An insert or remove moves m slots (at most about CAPACITY/2,
// the shorter side of the list), and an insert then writes its word; a read
// reads one slot and a rejected item moves nothing. The memory moves one slot
// per cycle through its single read port and single write port.
// Synchronous active-low reset empties the list; slot contents are not cleared.
// A result waiting in the output register does not block the next item; only
// the final commit of the next item holds until that result is taken.
module circular_deque_positional_core #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  cdq_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output cdq_pkg::t_rsp  o_rsp
);
    import cdq_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: decode dispatch, shift loop, word write, commit
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: slot memory, head/count, pointers and response register
    cdq_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

@@ design/cdq_ctrl.sv @@
// Sequencer for the positional circular deque.
// Depends on cdq_pkg (command and status types).
module cdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  cdq_pkg::t_sts  i_sts,
    output cdq_pkg::t_cmd  o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DISP   = 6'b000010,
        S_MOVE   = 6'b000100,
        S_PUT    = 6'b001000,
        S_READ   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.ok) begin
                    n_state = S_FINISH;
                end else if (i_sts.is_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                // the last pending write retires in the cycle moves_done is seen
                if (!i_sts.moves_done) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.is_insert) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FINISH;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

@@ design/cdq_datapath.sv @@
// Datapath for the positional circular deque: slot memory, head and count,
// request decode, shift pointers and the response register.
// Depends on cdq_pkg (item, command and status types).
module cdq_datapath #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cdq_pkg::t_cmd  i_cmd,
    output cdq_pkg::t_sts  o_sts,
    input  cdq_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output cdq_pkg::t_rsp  o_rsp
);
    import cdq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int SW = LW + 1;

    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] b,
                                              input logic [LW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(b) + SW'(k);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    function automatic logic [AW-1:0] slot_before(input logic [AW-1:0] b);
        return (b == '0) ? AW'(CAPACITY - 1) : b - AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] b);
        return (b == AW'(CAPACITY - 1)) ? '0 : b + AW'(1);
    endfunction

    logic [WORD_BITS-1:0] r_slot [CAPACITY];

    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    logic [1:0]           r_kind;
    logic                 r_ok;
    logic                 r_head_side;
    logic                 r_dir;
    logic [AW-1:0]        r_src;
    logic [AW-1:0]        r_prev;
    logic [AW-1:0]        r_tgt;
    logic [CW-1:0]        r_left;
    logic                 r_wr_pend;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] r_rd;
    logic                 r_out_valid;
    t_rsp                 r_rsp;

    // request decode, used on the load cycle
    logic [LW-1:0] n_l, p_l, half, k0, moves;
    logic          pos_nz, ins_ok, acc_ok, head_side, dir;
    logic [AW-1:0] wb, tgt;

    always_comb begin
        n_l       = LW'(r_count);
        p_l       = LW'(i_req.position);
        half      = n_l >> 1;
        pos_nz    = (p_l != '0);
        ins_ok    = (i_req.req_type == REQ_INSERT) && (r_count != CW'(CAPACITY))
                    && pos_nz && (p_l <= n_l + LW'(1));
        acc_ok    = ((i_req.req_type == REQ_REMOVE) || (i_req.req_type == REQ_READ))
                    && pos_nz && (p_l <= n_l);
        head_side = (p_l <= half);
        k0        = '0;
        moves     = '0;
        dir       = 1'b1;
        case (i_req.req_type)
            REQ_INSERT: begin
                if (head_side) begin
                    k0    = '0;
                    moves = p_l - LW'(1);
                    dir   = 1'b1;
                end else begin
                    k0    = n_l - LW'(1);
                    moves = n_l - p_l + LW'(1);
                    dir   = 1'b0;
                end
            end
            REQ_REMOVE: begin
                if (head_side) begin
                    k0    = p_l - LW'(2);
                    moves = p_l - LW'(1);
                    dir   = 1'b0;
                end else begin
                    k0    = p_l;
                    moves = n_l - p_l;
                    dir   = 1'b1;
                end
            end
            default: begin
                k0    = '0;
                moves = '0;
                dir   = 1'b1;
            end
        endcase
        wb  = slot_at(r_head, p_l - LW'(1));
        tgt = ((i_req.req_type == REQ_INSERT) && head_side) ? slot_before(wb) : wb;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.step;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_ok && (r_kind == REQ_INSERT)) begin
                    r_count <= r_count + CW'(1);
                    if (r_head_side) begin
                        r_head <= slot_before(r_head);
                    end
                end else if (r_ok && (r_kind == REQ_REMOVE)) begin
                    r_count <= r_count - CW'(1);
                    if (r_head_side) begin
                        r_head <= slot_after(r_head);
                    end
                end
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch and shift pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_req.req_type;
            r_ok        <= ins_ok || acc_ok;
            r_head_side <= head_side;
            r_dir       <= dir;
            r_src       <= slot_at(r_head, k0);
            r_left      <= CW'(moves);
            r_tgt       <= tgt;
            r_word      <= WORD_BITS'(i_req.value);
        end else if (i_cmd.step) begin
            r_src  <= r_dir ? slot_after(r_src) : slot_before(r_src);
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.step) begin
            r_prev <= r_src;
        end
    end

    // slot memory: one registered read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.step || i_cmd.rd) begin
            r_rd <= r_slot[i_cmd.step ? r_src : r_tgt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_slot[r_dir ? slot_before(r_prev) : slot_after(r_prev)] <= r_rd;
        end else if (i_cmd.put) begin
            r_slot[r_tgt] <= r_word;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.ok         <= r_ok;
            r_rsp.read_value <= (r_ok && (r_kind == REQ_READ)) ? VALUE_W'(r_rd) : '0;
            if (r_ok && (r_kind == REQ_INSERT)) begin
                r_rsp.count <= COUNT_W'(r_count + CW'(1));
            end else if (r_ok && (r_kind == REQ_REMOVE)) begin
                r_rsp.count <= COUNT_W'(r_count - CW'(1));
            end else begin
                r_rsp.count <= COUNT_W'(r_count);
            end
        end
    end

    assign o_sts.ok         = r_ok;
    assign o_sts.is_read    = (r_kind == REQ_READ);
    assign o_sts.is_insert  = (r_kind == REQ_INSERT);
    assign o_sts.moves_done = (r_left == '0);
    assign o_sts.out_busy   = r_out_valid && !i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ verif/tb_circular_deque_positional_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque_positional_core: positional insert,
// remove and read against a mirrored circular store, with random idling on both sides.
// Depends on cdq_pkg and the circular_deque_positional_core RTL.
module tb_circular_deque_positional_core;
    import cdq_pkg::*;

    localparam int LIST_CAP = 64;
    // req_type 3 has no meaning; the block must reject it
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_item  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp_item;

    // Mirror of the block state: circular word store, head slot and list length
    logic [31:0] slot_mirror [LIST_CAP];
    logic [5:0]  mirror_head = '0;
    int          deque_len   = 0;

    t_rsp rsp_expected [$];
    t_rsp rsp_want;
    int   error_count = 0;
    bit   no_idle     = 1'b0;   // when set, neither side idles
    int   stall_left  = 0;

    circular_deque_positional_core #(
        .CAPACITY  (LIST_CAP),
        .WORD_BITS (32)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_item),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_item)
    );

    always #5 clk = ~clk;

    // Generous fixed limit; a correct run needs well under a tenth of it
    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Physical slot of list offset k counted from base slot
    function automatic logic [5:0] slot_of(input logic [5:0] base, input int k);
        int s;
        s = (int'(base) + k) % LIST_CAP;
        return s[5:0];
    endfunction

    // Apply one request to the mirror and return the response it must produce
    function automatic t_rsp deque_apply(input t_req r);
        t_rsp       rsp;
        int         n;
        int         pos;
        int         k;
        logic [5:0] nh;
        rsp = '0;
        n   = deque_len;
        pos = int'(r.position);
        case (r.req_type)
            REQ_INSERT: begin
                if (n < LIST_CAP && pos >= 1 && pos <= n + 1) begin
                    if (pos <= n / 2) begin
                        // head side: move the leading words one slot towards the head
                        nh = mirror_head - 6'd1;
                        for (k = 0; k + 1 < pos; k++)
                            slot_mirror[slot_of(nh, k)] = slot_mirror[slot_of(mirror_head, k)];
                        slot_mirror[slot_of(nh, pos - 1)] = r.value;
                        mirror_head = nh;
                    end else begin
                        // tail side: move the trailing words one slot towards the tail
                        for (k = n; k > pos - 1; k--)
                            slot_mirror[slot_of(mirror_head, k)] =
                                slot_mirror[slot_of(mirror_head, k - 1)];
                        slot_mirror[slot_of(mirror_head, pos - 1)] = r.value;
                    end
                    deque_len = n + 1;
                    rsp.ok    = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (pos >= 1 && pos <= n) begin
                    if (pos <= n / 2) begin
                        for (k = pos - 1; k > 0; k--)
                            slot_mirror[slot_of(mirror_head, k)] =
                                slot_mirror[slot_of(mirror_head, k - 1)];
                        mirror_head = slot_of(mirror_head, 1);
                    end else begin
                        for (k = pos - 1; k + 1 < n; k++)
                            slot_mirror[slot_of(mirror_head, k)] =
                                slot_mirror[slot_of(mirror_head, k + 1)];
                    end
                    deque_len = n - 1;
                    rsp.ok    = 1'b1;
                end
            end
            REQ_READ: begin
                if (pos >= 1 && pos <= n) begin
                    rsp.read_value = slot_mirror[slot_of(mirror_head, pos - 1)];
                    rsp.ok         = 1'b1;
                end
            end
            default: begin
            end
        endcase
        rsp.count = deque_len[6:0];
        return rsp;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one request item; predict its response once the block accepts it
    task automatic send_item(input logic [1:0] kind, input int pos, input logic [31:0] val);
        int   gap;
        t_req r;
        gap        = pick_gap();
        r.req_type = kind;
        r.position = pos[6:0];
        r.value    = val;
        @(negedge clk);
        if (gap > 0) begin
            // drop valid for the gap, raise it again on a later falling edge
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= r;
        do @(posedge clk); while (!req_ready);
        rsp_expected.push_back(deque_apply(r));
    endtask

    // Randomly stall the response side; hold ready high while no_idle is set
    always @(negedge clk) begin
        if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(1, 3);
        end
    end

    // Compare every accepted response item with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (rsp_expected.size() == 0) begin
                $error("response item with no request outstanding");
                error_count++;
            end else begin
                rsp_want = rsp_expected.pop_front();
                if (rsp_item.ok !== rsp_want.ok) begin
                    $error("ok: expected %0d, got %0d", rsp_want.ok, rsp_item.ok);
                    error_count++;
                end
                if (rsp_item.read_value !== rsp_want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           rsp_want.read_value, rsp_item.read_value);
                    error_count++;
                end
                if (rsp_item.count !== rsp_want.count) begin
                    $error("count: expected %0d, got %0d", rsp_want.count, rsp_item.count);
                    error_count++;
                end
            end
        end
    end

    // Requests on an empty list, bad positions and the unused request code
    task automatic test_empty_list();
        send_item(REQ_READ,    1, 32'h0);
        send_item(REQ_REMOVE,  1, 32'hFFFF_FFFF);
        send_item(REQ_INSERT,  0, 32'h1234_5678);
        send_item(REQ_INSERT,  2, 32'h1234_5678);
        send_item(REQ_UNKNOWN, 1, 32'hFFFF_FFFF);
    endtask

    // Head and tail inserts, both sides of the split, reads and removes at the ends
    task automatic test_head_tail_ops();
        send_item(REQ_INSERT, 1, 32'h0000_0000);    // first word
        send_item(REQ_INSERT, 2, 32'hFFFF_FFFF);    // tail insert
        send_item(REQ_INSERT, 1, 32'hA5A5_A5A5);    // head insert, wraps head
        send_item(REQ_INSERT, 4, 32'h5A5A_5A5A);    // tail insert
        send_item(REQ_INSERT, 2, 32'h0F0F_0F0F);    // head side of the split
        send_item(REQ_INSERT, 4, 32'hF0F0_F0F0);    // tail side of the split
        send_item(REQ_READ,   1, 32'h0);
        send_item(REQ_READ,   6, 32'h0);
        send_item(REQ_READ,   3, 32'h0);
        send_item(REQ_READ,   7, 32'h0);            // one past the end
        send_item(REQ_READ, 127, 32'hFFFF_FFFF);    // every position bit set
        send_item(REQ_INSERT, 127, 32'h1);
        send_item(REQ_INSERT, 8, 32'h1);            // beyond count+1
        send_item(REQ_REMOVE, 7, 32'h0);            // beyond count
        send_item(REQ_REMOVE, 0, 32'h0);
        send_item(REQ_REMOVE, 2, 32'h0);            // head side
        send_item(REQ_REMOVE, 4, 32'h0);            // tail side
        send_item(REQ_REMOVE, 1, 32'h0);            // head
        send_item(REQ_REMOVE, 3, 32'h0);            // tail
        send_item(REQ_UNKNOWN, 2, 32'h0);
    endtask

    // Fill to capacity, hit the full list, then drain with removes and reads
    task automatic test_fill_and_drain();
        while (deque_len < LIST_CAP)
            send_item(REQ_INSERT, $urandom_range(1, deque_len + 1), $urandom());
        send_item(REQ_INSERT, 1,  $urandom());
        send_item(REQ_INSERT, 65, $urandom());
        send_item(REQ_INSERT, 33, $urandom());
        send_item(REQ_READ,   64, 32'h0);
        send_item(REQ_READ,   65, 32'h0);
        send_item(REQ_REMOVE, 65, 32'h0);
        while (deque_len > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_item(REQ_READ, $urandom_range(1, deque_len), $urandom());
            send_item(REQ_REMOVE, $urandom_range(1, deque_len), $urandom());
        end
    endtask

    // Random mix; steer the length away from the ends so it wanders the whole range
    task automatic test_random_mix(input int n_items);
        int         i;
        int         sel;
        int         lim;
        int         pos;
        logic [1:0] kind;
        for (i = 0; i < n_items; i++) begin
            if (i % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (deque_len < 8)
                kind = (sel < 60) ? REQ_INSERT : (sel < 80) ? REQ_READ :
                       (sel < 95) ? REQ_REMOVE : REQ_UNKNOWN;
            else if (deque_len > 56)
                kind = (sel < 25) ? REQ_INSERT : (sel < 50) ? REQ_READ :
                       (sel < 95) ? REQ_REMOVE : REQ_UNKNOWN;
            else
                kind = (sel < 40) ? REQ_INSERT : (sel < 65) ? REQ_READ :
                       (sel < 95) ? REQ_REMOVE : REQ_UNKNOWN;
            lim = (kind == REQ_INSERT) ? deque_len + 1 : deque_len;
            sel = $urandom_range(0, 99);
            if (sel < 85 && lim >= 1)
                pos = $urandom_range(1, lim);
            else if (sel < 95)
                pos = (sel % 2 == 0) ? 0 : lim + 1;
            else
                pos = $urandom_range(0, 127);
            send_item(kind, pos, $urandom());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_head_tail_ops();
        test_fill_and_drain();
        test_random_mix(225);

        @(negedge clk);
        req_valid <= 1'b0;
        // drain outstanding responses, then let the block settle
        while (rsp_expected.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
